// ===== rtl/core/ecal_pkg.sv =====
// Shared widths, constants, types and calendar helpers for the epoch to calendar converter.
package ecal_pkg;

    localparam int SecsW  = 32;
    localparam int YearW  = 12;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int HourW  = 5;
    localparam int MinW   = 6;
    localparam int SecW   = 6;
    localparam int DaysW  = 16;
    localparam int YqW    = 8;
    localparam int TodW   = 17;
    localparam int DoyW   = 9;

    localparam logic [25:0] DayRecip    = 26'd50903317;
    localparam logic [16:0] YearRecip   = 17'd91930;
    localparam logic [13:0] HourRecip   = 14'd9321;
    localparam logic [10:0] MinRecip    = 11'd1093;
    localparam logic [16:0] SecsPerDay  = 17'd86400;
    localparam logic [11:0] SecsPerHour = 12'd3600;
    localparam logic [5:0]  SecsPerMin  = 6'd60;
    localparam logic [8:0]  DaysPerYear = 9'd365;
    localparam logic [11:0] BaseYear    = 12'd1970;
    localparam logic [7:0]  CenturyOff  = 8'd130;
    localparam logic [7:0]  CenturyPast = 8'd131;

    typedef struct packed {
        logic [DaysW-1:0] days;
        logic [YqW-1:0]   yq;
        logic [TodW-1:0]  tod;
    } t_day_info;

    function automatic logic is_leap_off(input logic [YqW-1:0] k);
        return (k[1:0] == 2'd2) && (k != CenturyOff);
    endfunction

    function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] m,
                                                    input logic leap);
        logic [DoyW-1:0] base;
        case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            default: base = 9'd334;
        endcase
        return base + ((leap && (m >= 4'd2)) ? 9'd1 : 9'd0);
    endfunction

endpackage

// ===== rtl/core/ecal_split.sv =====
// Three-stage split of epoch seconds into whole days, time of day and year estimate.
module ecal_split (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [31:0]             i_secs,
    output logic                    o_valid,
    output ecal_pkg::t_day_info     o_info
);
    import ecal_pkg::*;

    logic [2:0]        r_vld;
    logic [50:0]       r1_prod;
    logic [SecsW-1:0]  r1_secs;
    logic [DaysW-1:0]  r2_days;
    logic [SecsW-1:0]  r2_secs;
    logic [SecsW-1:0]  r2_dmul;
    logic [32:0]       r2_yprod;
    t_day_info         r_info;

    logic [50:0]       n1_prod;
    logic [DaysW-1:0]  n2_days;
    logic [SecsW-1:0]  n2_dmul;
    logic [32:0]       n2_yprod;
    t_day_info         n_info;

    assign n1_prod  = 51'(i_secs[31:7]) * 51'(DayRecip);
    assign n2_days  = r1_prod[50:35];
    assign n2_dmul  = 32'(n2_days) * 32'(SecsPerDay);
    assign n2_yprod = 33'(n2_days) * 33'(YearRecip);

    always_comb begin
        n_info.days = r2_days;
        n_info.yq   = r2_yprod[32:25];
        n_info.tod  = TodW'(r2_secs - r2_dmul);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod  <= n1_prod;
        r1_secs  <= i_secs;
        r2_days  <= n2_days;
        r2_secs  <= r1_secs;
        r2_dmul  <= n2_dmul;
        r2_yprod <= n2_yprod;
        r_info   <= n_info;
    end

    assign o_valid = r_vld[2];
    assign o_info  = r_info;

endmodule

// ===== rtl/core/ecal_date.sv =====
// Five-stage year correction and month/day split of the whole day count.
module ecal_date (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  ecal_pkg::t_day_info     i_info,
    output logic                    o_valid,
    output logic [11:0]             o_year,
    output logic [3:0]              o_month,
    output logic [4:0]              o_day
);
    import ecal_pkg::*;

    logic [4:0]          r_vld;
    logic [DaysW-1:0]    r_a_days;
    logic [YqW-1:0]      r_a_yq;
    logic [16:0]         r_a_qmul;
    logic [5:0]          r_a_leaps;
    logic signed [17:0]  r_b_rem;
    logic [YqW-1:0]      r_b_yq;
    logic [YqW-1:0]      r_c_yoff;
    logic [DoyW-1:0]     r_c_doy;
    logic                r_c_leap;
    logic [YqW-1:0]      r_d_yoff;
    logic [DoyW-1:0]     r_d_doy;
    logic [DoyW-1:0]     r_d_start;
    logic [MonthW-1:0]   r_d_month;
    logic [YearW-1:0]    r_year;
    logic [MonthW-1:0]   r_month;
    logic [DayW-1:0]     r_day;

    logic [16:0]         n_a_qmul;
    logic [5:0]          n_a_leaps;
    logic signed [17:0]  n_b_rem;
    logic [YqW-1:0]      n_c_yoff;
    logic [DoyW-1:0]     n_c_doy;
    logic                n_c_leap;
    logic [MonthW-1:0]   n_d_month;
    logic [DoyW-1:0]     n_d_start;

    assign n_a_qmul  = 17'(i_info.yq) * 17'(DaysPerYear);
    assign n_a_leaps = 6'((9'(i_info.yq) + 9'd1) >> 2)
                     - ((i_info.yq >= CenturyPast) ? 6'd1 : 6'd0);

    assign n_b_rem = $signed({2'b00, r_a_days}) - $signed({1'b0, r_a_qmul})
                   - $signed({12'b0, r_a_leaps});

    always_comb begin
        if (r_b_rem[17]) begin
            n_c_yoff = r_b_yq - 8'd1;
            n_c_leap = is_leap_off(n_c_yoff);
            n_c_doy  = r_b_rem[8:0] + DaysPerYear + (n_c_leap ? 9'd1 : 9'd0);
        end else begin
            n_c_yoff = r_b_yq;
            n_c_leap = is_leap_off(r_b_yq);
            n_c_doy  = r_b_rem[8:0];
        end
    end

    always_comb begin
        n_d_month = '0;
        for (int m = 1; m < 12; m++) begin
            if (r_c_doy >= month_start(MonthW'(m), r_c_leap)) begin
                n_d_month = n_d_month + 4'd1;
            end
        end
        n_d_start = month_start(n_d_month, r_c_leap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_days  <= i_info.days;
        r_a_yq    <= i_info.yq;
        r_a_qmul  <= n_a_qmul;
        r_a_leaps <= n_a_leaps;
        r_b_rem   <= n_b_rem;
        r_b_yq    <= r_a_yq;
        r_c_yoff  <= n_c_yoff;
        r_c_doy   <= n_c_doy;
        r_c_leap  <= n_c_leap;
        r_d_yoff  <= r_c_yoff;
        r_d_doy   <= r_c_doy;
        r_d_start <= n_d_start;
        r_d_month <= n_d_month;
        r_year    <= BaseYear + YearW'(r_d_yoff);
        r_month   <= r_d_month + 4'd1;
        r_day     <= DayW'(r_d_doy - r_d_start + 9'd1);
    end

    assign o_valid = r_vld[4];
    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;

endmodule

// ===== rtl/core/ecal_clock.sv =====
// Five-stage split of the second of the day into hour, minute and second.
module ecal_clock (
    input  logic         i_clk,
    input  logic [16:0]  i_tod,
    output logic [4:0]   o_hour,
    output logic [5:0]   o_minute,
    output logic [5:0]   o_second
);
    import ecal_pkg::*;

    logic [26:0]        r_a_hprod;
    logic [TodW-1:0]    r_a_tod;
    logic [HourW-1:0]   r_b_hh;
    logic [11:0]        r_b_rest;
    logic [20:0]        r_c_mprod;
    logic [HourW-1:0]   r_c_hh;
    logic [11:0]        r_c_rest;
    logic [HourW-1:0]   r_d_hh;
    logic [MinW-1:0]    r_d_mm;
    logic [SecW-1:0]    r_d_ss;
    logic [HourW-1:0]   r_hour;
    logic [MinW-1:0]    r_minute;
    logic [SecW-1:0]    r_second;

    logic [26:0]        n_a_hprod;
    logic [HourW-1:0]   n_b_hh;
    logic [TodW-1:0]    n_b_rest;
    logic [20:0]        n_c_mprod;
    logic [MinW-1:0]    n_d_mm;
    logic [11:0]        n_d_ss;

    assign n_a_hprod = 27'(i_tod[16:4]) * 27'(HourRecip);
    assign n_b_hh    = r_a_hprod[25:21];
    assign n_b_rest  = r_a_tod - 17'(n_b_hh) * 17'(SecsPerHour);
    assign n_c_mprod = 21'(r_b_rest[11:2]) * 21'(MinRecip);
    assign n_d_mm    = r_c_mprod[19:14];
    assign n_d_ss    = r_c_rest - 12'(n_d_mm) * 12'(SecsPerMin);

    always_ff @(posedge i_clk) begin
        r_a_hprod <= n_a_hprod;
        r_a_tod   <= i_tod;
        r_b_hh    <= n_b_hh;
        r_b_rest  <= n_b_rest[11:0];
        r_c_mprod <= n_c_mprod;
        r_c_hh    <= r_b_hh;
        r_c_rest  <= r_b_rest;
        r_d_hh    <= r_c_hh;
        r_d_mm    <= n_d_mm;
        r_d_ss    <= n_d_ss[5:0];
        r_hour    <= r_d_hh;
        r_minute  <= r_d_mm;
        r_second  <= r_d_ss;
    end

    assign o_hour   = r_hour;
    assign o_minute = r_minute;
    assign o_second = r_second;

endmodule

// ===== rtl/core/epoch_seconds_to_calendar_core.sv =====
// Top level of the pipelined epoch seconds to Gregorian date and time converter.
//
// Request channel: drive i_epoch_seconds and raise i_start; the request is
// taken at the rising edge where i_start is high and o_busy is low. o_busy
// stays low, so a request may be issued in every cycle.
// Result channel: o_valid is high for exactly one cycle with o_year,
// o_month, o_day, o_hour, o_minute and o_second; the result is taken at the
// edge that ends that cycle. The receiver cannot stall the block.
// Throughput: one request per cycle, set by the eight-stage pipeline: three
// stages split seconds into days and time of day with constant-reciprocal
// multiplies, five stages correct the year and peel off the month while the
// time of day is split into hour, minute and second.
// Reset: synchronous, active low on i_rst_n; it clears the valid bits in
// flight, so requests in the pipeline at reset give no result.
module epoch_seconds_to_calendar_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    output logic         o_busy,
    input  logic [31:0]  i_epoch_seconds,
    output logic         o_valid,
    output logic [11:0]  o_year,
    output logic [3:0]   o_month,
    output logic [4:0]   o_day,
    output logic [4:0]   o_hour,
    output logic [5:0]   o_minute,
    output logic [5:0]   o_second
);
    import ecal_pkg::*;

    logic       split_valid;
    t_day_info  split_info;

    assign o_busy = 1'b0;

    ecal_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_secs  (i_epoch_seconds),
        .o_valid (split_valid),
        .o_info  (split_info)
    );

    ecal_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .i_info  (split_info),
        .o_valid (o_valid),
        .o_year  (o_year),
        .o_month (o_month),
        .o_day   (o_day)
    );

    ecal_clock u_clock (
        .i_clk    (i_clk),
        .i_tod    (split_info.tod),
        .o_hour   (o_hour),
        .o_minute (o_minute),
        .o_second (o_second)
    );

endmodule

// ===== tb/sv/tb_epoch_seconds_to_calendar_core.sv =====
// Self-checking testbench for the epoch seconds to Gregorian calendar converter.
module tb_epoch_seconds_to_calendar_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ecal_pkg::*;

    localparam int NumRandom    = 1650;
    localparam int QuietTail    = 150;
    localparam int DrainCycles  = 16;
    localparam int NumDirected  = 24;
    localparam int February     = 1;
    localparam int December     = 11;
    localparam int SecsInDay    = 86400;

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
        logic [SecW-1:0]   second;
    } t_cal;

    typedef struct packed {
        logic [SecsW-1:0] secs;
        logic             has_cal;
        t_cal             cal;
    } t_dir_row;

    localparam t_dir_row DirectedRows [NumDirected] = '{
        '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
        '{32'd1,          1'b0, '0},
        '{32'd59,         1'b0, '0},
        '{32'd60,         1'b0, '0},
        '{32'd3599,       1'b0, '0},
        '{32'd3600,       1'b0, '0},
        '{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
        '{32'd86400,      1'b0, '0},
        '{32'd31535999,   1'b0, '0},
        '{32'd31536000,   1'b0, '0},
        '{32'd68169600,   1'b0, '0},
        '{32'd68256000,   1'b0, '0},
        '{32'd94694399,   1'b0, '0},
        '{32'd94694400,   1'b0, '0},
        '{32'd126230399,  1'b0, '0},
        '{32'd126230400,  1'b0, '0},
        '{32'd951782400,  1'b0, '0},
        '{32'd951868800,  1'b0, '0},
        '{32'd978307199,  1'b0, '0},
        '{32'd2147483647, 1'b0, '0},
        '{32'd2147483648, 1'b0, '0},
        '{32'd4102444799, 1'b0, '0},
        '{32'd4107542400, 1'b0, '0},
        '{32'd4294967295, 1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15}}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic [SecsW-1:0]  i_epoch_seconds = '0;
    logic              o_busy;
    logic              o_valid;
    logic [YearW-1:0]  o_year;
    logic [MonthW-1:0] o_month;
    logic [DayW-1:0]   o_day;
    logic [HourW-1:0]  o_hour;
    logic [MinW-1:0]   o_minute;
    logic [SecW-1:0]   o_second;

    t_cal pending_dates [$];
    int   n_errors = 0;
    bit   idle_burst = 1'b0;

    epoch_seconds_to_calendar_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit leap_year(input int yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int leap_days_upto(input int yr);
        return yr / 4 - yr / 100 + yr / 400;
    endfunction

    function automatic int days_to_new_year(input int yr);
        return (yr - 1970) * 365 + leap_days_upto(yr - 1) - leap_days_upto(1969);
    endfunction

    function automatic int month_days(input int mo, input int yr);
        int len;
        case (mo)
            3, 5, 8, 10: len = 30;
            February:    len = leap_year(yr) ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    function automatic t_cal seconds_to_calendar(input logic [SecsW-1:0] secs);
        int unsigned days;
        int unsigned tod;
        int          yr;
        int          rem;
        int          mo;
        t_cal        r;
        days = secs / SecsInDay;
        tod  = secs % SecsInDay;
        yr   = 1970 + int'(days / 365);
        rem  = int'(days) - days_to_new_year(yr);
        if (rem < 0) begin
            yr  = yr - 1;
            rem = rem + (leap_year(yr) ? 366 : 365);
        end
        mo = 0;
        while (mo < December && rem >= month_days(mo, yr)) begin
            rem = rem - month_days(mo, yr);
            mo++;
        end
        r.year   = YearW'(yr);
        r.month  = MonthW'(mo + 1);
        r.day    = DayW'(rem + 1);
        r.hour   = HourW'(tod / 3600);
        r.minute = MinW'((tod % 3600) / 60);
        r.second = SecW'(tod % 60);
        return r;
    endfunction

    function automatic logic [SecsW-1:0] pick_epoch();
        longint s;
        int     yr;
        s = -1;
        case ($urandom_range(0, 9))
            4, 5: begin
                yr = $urandom_range(1971, 2106);
                s  = longint'(days_to_new_year(yr)) * SecsInDay
                   + $urandom_range(0, 6 * SecsInDay) - 3 * SecsInDay;
            end
            6, 7: begin
                yr = $urandom_range(1970, 2105);
                s  = longint'(days_to_new_year(yr) + 58) * SecsInDay
                   + $urandom_range(0, 4 * SecsInDay) - 2 * SecsInDay;
            end
            8:       s = longint'(32'hFFFF_FFFF) - $urandom_range(0, 200 * SecsInDay);
            9:       s = $urandom_range(0, 400 * SecsInDay);
            default: s = -1;
        endcase
        if (s < 0 || s > longint'(32'hFFFF_FFFF)) begin
            return $urandom;
        end
        return SecsW'(s);
    endfunction

    task automatic issue_request(input logic [SecsW-1:0] secs, input bit has_cal,
                                 input t_cal cal, input bit allow_gap);
        if (allow_gap && idle_burst && $urandom_range(0, 2) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_epoch_seconds <= secs;
        do @(posedge i_clk); while (o_busy);
        pending_dates.push_back(has_cal ? cal : seconds_to_calendar(secs));
    endtask

    always @(posedge i_clk) begin
        t_cal want;
        if (i_rst_n && o_valid) begin
            if (pending_dates.size() == 0) begin
                $error("unexpected result %0d-%0d-%0d %0d:%0d:%0d",
                       o_year, o_month, o_day, o_hour, o_minute, o_second);
                n_errors++;
            end else begin
                want = pending_dates.pop_front();
                if (o_year !== want.year) begin
                    $error("year: expected %0d, got %0d", want.year, o_year);
                    n_errors++;
                end
                if (o_month !== want.month) begin
                    $error("month: expected %0d, got %0d", want.month, o_month);
                    n_errors++;
                end
                if (o_day !== want.day) begin
                    $error("day: expected %0d, got %0d", want.day, o_day);
                    n_errors++;
                end
                if (o_hour !== want.hour) begin
                    $error("hour: expected %0d, got %0d", want.hour, o_hour);
                    n_errors++;
                end
                if (o_minute !== want.minute) begin
                    $error("minute: expected %0d, got %0d", want.minute, o_minute);
                    n_errors++;
                end
                if (o_second !== want.second) begin
                    $error("second: expected %0d, got %0d", want.second, o_second);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, leap days, year overshoot, December ends
        idle_burst = 1'b1;
        for (int i = 0; i < NumDirected; i++) begin
            issue_request(DirectedRows[i].secs, DirectedRows[i].has_cal,
                          DirectedRows[i].cal, 1'b1);
        end

        for (int n = 0; n < NumRandom; n++) begin
            if (n % 40 == 0) begin
                idle_burst = $urandom_range(0, 1);
            end
            issue_request(pick_epoch(), 1'b0, '0, n < NumRandom - QuietTail);
        end
        i_start <= 1'b0;

        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ecal_pkg.sv
rtl/core/ecal_split.sv
rtl/core/ecal_date.sv
rtl/core/ecal_clock.sv
rtl/core/epoch_seconds_to_calendar_core.sv
tb/sv/tb_epoch_seconds_to_calendar_core.sv
